// ===== rtl/hpa_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV pixel adjust package
// Shared types and constants for the HSV pixel adjust pipeline.
// ----------------------------------------------------------------------------
package hpa_pkg;

   localparam logic [16:0] ONE_FX     = 17'd65536;
   localparam logic [18:0] SIX_FX     = 19'd393216;
   localparam logic [18:0] HUE_CAP_FX = 19'd392123;

   // Adjustment modes.
   localparam logic [2:0] MODE_HUE       = 3'd0;
   localparam logic [2:0] MODE_SAT       = 3'd1;
   localparam logic [2:0] MODE_VAL       = 3'd2;
   localparam logic [2:0] MODE_HIGHLIGHT = 3'd3;
   localparam logic [2:0] MODE_SHADOW    = 3'd4;

   // Register indexes.
   localparam logic [1:0] CSR_MODE   = 2'd0;
   localparam logic [1:0] CSR_AMOUNT = 2'd1;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       frame_end;
   } pixel_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [9:0]  amount;
      logic [9:0]         amount_mag;
      logic signed [19:0] hue_step;
      logic signed [17:0] pct_step;
   } cfg_type;

   typedef struct packed {
      pixel_type   pix;
      logic        pass;
      logic        hue_zero;
      logic        hue_neg;
      logic [2:0]  hue_base;
      logic [16:0] hue_q;
      logic [16:0] sat;
      logic [16:0] val;
   } conv_type;

   typedef struct packed {
      pixel_type   pix;
      logic        pass;
      logic [18:0] hue;
      logic [16:0] sat;
      logic [16:0] val;
   } hsv_type;

endpackage

// ===== rtl/hpa_if.sv =====
// ----------------------------------------------------------------------------
// HSV pixel adjust channels
// Valid/ready pixel channels for the request and response sides.
// ----------------------------------------------------------------------------
interface hpa_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   logic [7:0] alpha_in;
   logic       frame_end_in;

   modport source (output valid, red_in, green_in, blue_in, alpha_in, frame_end_in,
                   input ready);
   modport sink   (input valid, red_in, green_in, blue_in, alpha_in, frame_end_in,
                   output ready);
endinterface

interface hpa_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic [7:0] alpha_out;
   logic       frame_end_out;

   modport source (output valid, red_out, green_out, blue_out, alpha_out, frame_end_out,
                   input ready);
   modport sink   (input valid, red_out, green_out, blue_out, alpha_out, frame_end_out,
                   output ready);
endinterface

// ===== rtl/hpa_rgb2hsv.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV conversion
// Finds max, min and sector, then runs two pipelined long divisions.
// ----------------------------------------------------------------------------
module hpa_rgb2hsv (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  hpa_pkg::pixel_type in_pix,
   input  hpa_pkg::cfg_type   cfg,
   output logic               out_valid,
   output hpa_pkg::conv_type  out_conv
);
   import hpa_pkg::*;

   localparam int DivStages = 4;
   localparam int StepsPerStage = 4;

   typedef struct packed {
      pixel_type   pix;
      logic        pass;
      logic        hue_zero;
      logic        hue_neg;
      logic [2:0]  hue_base;
      logic [7:0]  hue_den;
      logic [7:0]  hue_rem;
      logic [16:0] hue_q;
      logic [7:0]  sat_den;
      logic [7:0]  sat_rem;
      logic [16:0] sat_q;
      logic [16:0] val;
   } div_type;

   // One restoring step; the remainder stays below the divisor.
   function automatic logic [8:0] div_step(input logic [7:0] rem, input logic [7:0] den);
      logic [8:0] r2;
      r2 = {rem, 1'b0};
      if (r2 >= {1'b0, den}) begin
         div_step = {1'b1, 8'(r2 - {1'b0, den})};
      end else begin
         div_step = {1'b0, r2[7:0]};
      end
   endfunction

   div_type st_ff [DivStages+1];
   div_type st_in;
   logic    vld_ff [DivStages+1];

   always_comb begin
      logic [7:0] r, g, b, mx, mn, d;
      r = in_pix.red;
      g = in_pix.green;
      b = in_pix.blue;
      st_in = '0;
      st_in.pix = in_pix;

      unique case (cfg.mode) inside
         MODE_HUE: begin
            st_in.pass = !($signed(cfg.amount) >= -10'sd359 &&
                           $signed(cfg.amount) <= 10'sd360);
         end
         MODE_SAT, MODE_VAL, MODE_HIGHLIGHT, MODE_SHADOW: begin
            st_in.pass = !($signed(cfg.amount) >= -10'sd100 &&
                           $signed(cfg.amount) <= 10'sd100);
         end
         default: begin
            st_in.pass = 1'b1;
         end
      endcase

      mn = (r < g) ? r : g;
      mn = (mn < b) ? mn : b;
      // Ties on the maximum go to red first, then green.
      if (r >= g && r >= b) begin
         mx = r;
         st_in.hue_neg  = (g < b);
         st_in.hue_base = (g < b) ? 3'd6 : 3'd0;
         st_in.hue_rem  = (g < b) ? 8'(b - g) : 8'(g - b);
      end else if (g >= b) begin
         mx = g;
         st_in.hue_neg  = (b < r);
         st_in.hue_base = 3'd2;
         st_in.hue_rem  = (b < r) ? 8'(r - b) : 8'(b - r);
      end else begin
         mx = b;
         st_in.hue_neg  = (r < g);
         st_in.hue_base = 3'd4;
         st_in.hue_rem  = (r < g) ? 8'(g - r) : 8'(r - g);
      end
      d = mx - mn;
      st_in.hue_zero = (d == 8'd0);
      st_in.hue_den  = (d == 8'd0) ? 8'd1 : d;
      st_in.sat_den  = (mx == 8'd0) ? 8'd1 : mx;
      st_in.sat_rem  = d;
      // ceil(mx * 65536 / 255) is 257 * mx, plus one for any nonzero mx.
      st_in.val = {1'b0, mx, mx} + {16'd0, (mx != 8'd0)};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= st_in;
      end
   end

   for (genvar k = 0; k < DivStages; k++) begin : g_div
      div_type nxt;

      always_comb begin
         logic [8:0] hs, ss;
         nxt = st_ff[k];
         if (k == 0) begin
            // The numerator never exceeds the divisor, so the top bit is one compare.
            if (nxt.hue_rem >= nxt.hue_den) begin
               nxt.hue_q   = {nxt.hue_q[15:0], 1'b1};
               nxt.hue_rem = nxt.hue_rem - nxt.hue_den;
            end else begin
               nxt.hue_q = {nxt.hue_q[15:0], 1'b0};
            end
            if (nxt.sat_rem >= nxt.sat_den) begin
               nxt.sat_q   = {nxt.sat_q[15:0], 1'b1};
               nxt.sat_rem = nxt.sat_rem - nxt.sat_den;
            end else begin
               nxt.sat_q = {nxt.sat_q[15:0], 1'b0};
            end
         end
         for (int j = 0; j < StepsPerStage; j++) begin
            hs = div_step(nxt.hue_rem, nxt.hue_den);
            ss = div_step(nxt.sat_rem, nxt.sat_den);
            nxt.hue_q   = {nxt.hue_q[15:0], hs[8]};
            nxt.hue_rem = hs[7:0];
            nxt.sat_q   = {nxt.sat_q[15:0], ss[8]};
            nxt.sat_rem = ss[7:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[k+1] <= nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DivStages; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int k = 0; k < DivStages; k++) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end
   end

   assign out_valid         = vld_ff[DivStages];
   assign out_conv.pix      = st_ff[DivStages].pix;
   assign out_conv.pass     = st_ff[DivStages].pass;
   assign out_conv.hue_zero = st_ff[DivStages].hue_zero;
   assign out_conv.hue_neg  = st_ff[DivStages].hue_neg;
   assign out_conv.hue_base = st_ff[DivStages].hue_base;
   assign out_conv.hue_q    = st_ff[DivStages].hue_q;
   assign out_conv.sat      = st_ff[DivStages].sat_q;
   assign out_conv.val      = st_ff[DivStages].val;

endmodule

// ===== rtl/hpa_adjust.sv =====
// ----------------------------------------------------------------------------
// HSV adjustment
// Applies the configured hue, saturation, value, highlight or shadow adjustment with clamping.
// ----------------------------------------------------------------------------
module hpa_adjust (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  hpa_pkg::conv_type in_conv,
   input  hpa_pkg::cfg_type  cfg,
   output logic              out_valid,
   output hpa_pkg::hsv_type  out_hsv
);
   import hpa_pkg::*;

   // ceil(2^30 / 100): exact quotient for products below 2^23.
   localparam logic [23:0] RECIP_100 = 24'd10737419;

   function automatic logic [16:0] clamp_unit(input logic signed [18:0] x);
      if (x < 19'sd0) begin
         clamp_unit = 17'd0;
      end else if (x > $signed({2'b00, ONE_FX})) begin
         clamp_unit = ONE_FX;
      end else begin
         clamp_unit = x[16:0];
      end
   endfunction

   hsv_type     a_in, a_ff, b_ff, c_in, c_ff;
   logic [22:0] prod_in, prod_ff;
   logic [16:0] quo_in, quo_ff;
   logic        a_vld_ff, b_vld_ff, c_vld_ff;

   always_comb begin
      logic [18:0]        h_raw;
      logic signed [20:0] hsum;
      logic signed [18:0] ssum, vsum;
      logic [16:0]        w;
      if (in_conv.hue_zero) begin
         h_raw = 19'd0;
      end else if (in_conv.hue_neg) begin
         h_raw = {in_conv.hue_base, 16'd0} - {2'b00, in_conv.hue_q};
      end else begin
         h_raw = {in_conv.hue_base, 16'd0} + {2'b00, in_conv.hue_q};
      end
      hsum = $signed({2'b00, h_raw}) + 21'(cfg.hue_step);
      ssum = $signed({2'b00, in_conv.sat}) + 19'(cfg.pct_step);
      vsum = $signed({2'b00, in_conv.val}) + 19'(cfg.pct_step);

      a_in.pix  = in_conv.pix;
      a_in.pass = in_conv.pass;
      a_in.hue  = h_raw;
      a_in.sat  = in_conv.sat;
      a_in.val  = in_conv.val;
      case (cfg.mode)
         MODE_HUE: begin
            // The shift clamps at the ends of the circle instead of wrapping.
            if (hsum > $signed({2'b00, SIX_FX})) begin
               a_in.hue = HUE_CAP_FX;
            end else if (hsum == $signed({2'b00, SIX_FX}) || hsum < 21'sd0) begin
               a_in.hue = 19'd0;
            end else begin
               a_in.hue = hsum[18:0];
            end
         end
         MODE_SAT: a_in.sat = clamp_unit(ssum);
         MODE_VAL: a_in.val = clamp_unit(vsum);
         default: ;
      endcase

      w = (cfg.mode == MODE_SHADOW) ? ONE_FX - in_conv.val : in_conv.val;
      prod_in = 23'({16'd0, cfg.amount_mag[6:0]} * {6'd0, w});
   end

   always_comb begin
      logic [46:0] p;
      p = {24'd0, prod_ff} * {23'd0, RECIP_100};
      quo_in = p[46:30];
   end

   always_comb begin
      logic signed [18:0] vs;
      c_in = b_ff;
      if (cfg.amount[9]) begin
         vs = $signed({2'b00, b_ff.val}) - $signed({2'b00, quo_ff});
      end else begin
         vs = $signed({2'b00, b_ff.val}) + $signed({2'b00, quo_ff});
      end
      if (cfg.mode == MODE_HIGHLIGHT || cfg.mode == MODE_SHADOW) begin
         c_in.val = clamp_unit(vs);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= in_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
      end
      if (en) begin
         a_ff    <= a_in;
         prod_ff <= prod_in;
         b_ff    <= a_ff;
         quo_ff  <= quo_in;
         c_ff    <= c_in;
      end
   end

   assign out_valid = c_vld_ff;
   assign out_hsv   = c_ff;

endmodule

// ===== rtl/hpa_hsv2rgb.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB conversion
// Chroma and secondary component, sector select, and the output register.
// ----------------------------------------------------------------------------
module hpa_hsv2rgb (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  hpa_pkg::hsv_type   in_hsv,
   output logic               out_valid,
   output hpa_pkg::pixel_type out_pix
);
   import hpa_pkg::*;

   typedef struct packed {
      pixel_type   pix;
      logic        pass;
      logic [2:0]  sector;
      logic [16:0] val;
      logic [16:0] chroma;
      logic [16:0] span;
   } chroma_type;

   typedef struct packed {
      pixel_type   pix;
      logic        pass;
      logic [2:0]  sector;
      logic [16:0] chroma;
      logic [16:0] second;
      logic [16:0] base;
   } comp_type;

   // Scales a unit fraction to 0..255 with truncation.
   function automatic logic [7:0] to_chan(input logic [16:0] t);
      logic [24:0] p;
      p = {t, 8'd0} - {8'd0, t};
      to_chan = p[23:16];
   endfunction

   chroma_type i_in, i_ff;
   comp_type   j_in, j_ff;
   pixel_type  k_in, k_ff;
   logic       i_vld_ff, j_vld_ff, k_vld_ff;

   always_comb begin
      logic [33:0] p;
      logic [16:0] dev;
      p = {17'd0, in_hsv.val} * {17'd0, in_hsv.sat};
      if (in_hsv.hue[16]) begin
         dev = {1'b0, in_hsv.hue[15:0]};
      end else begin
         dev = ONE_FX - {1'b0, in_hsv.hue[15:0]};
      end
      i_in.pix    = in_hsv.pix;
      i_in.pass   = in_hsv.pass;
      i_in.sector = in_hsv.hue[18:16];
      i_in.val    = in_hsv.val;
      i_in.chroma = p[32:16];
      i_in.span   = ONE_FX - dev;
   end

   always_comb begin
      logic [33:0] p;
      p = {17'd0, i_ff.chroma} * {17'd0, i_ff.span};
      j_in.pix    = i_ff.pix;
      j_in.pass   = i_ff.pass;
      j_in.sector = i_ff.sector;
      j_in.chroma = i_ff.chroma;
      j_in.second = p[32:16];
      j_in.base   = i_ff.val - i_ff.chroma;
   end

   always_comb begin
      logic [16:0] cr, cg, cb;
      case (j_ff.sector)
         3'd0: begin
            cr = j_ff.chroma; cg = j_ff.second; cb = 17'd0;
         end
         3'd1: begin
            cr = j_ff.second; cg = j_ff.chroma; cb = 17'd0;
         end
         3'd2: begin
            cr = 17'd0; cg = j_ff.chroma; cb = j_ff.second;
         end
         3'd3: begin
            cr = 17'd0; cg = j_ff.second; cb = j_ff.chroma;
         end
         3'd4: begin
            cr = j_ff.second; cg = 17'd0; cb = j_ff.chroma;
         end
         default: begin
            cr = j_ff.chroma; cg = 17'd0; cb = j_ff.second;
         end
      endcase
      k_in = j_ff.pix;
      if (!j_ff.pass) begin
         k_in.red   = to_chan(cr + j_ff.base);
         k_in.green = to_chan(cg + j_ff.base);
         k_in.blue  = to_chan(cb + j_ff.base);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_vld_ff <= 1'b0;
         j_vld_ff <= 1'b0;
         k_vld_ff <= 1'b0;
      end else if (en) begin
         i_vld_ff <= in_valid;
         j_vld_ff <= i_vld_ff;
         k_vld_ff <= j_vld_ff;
      end
      if (en) begin
         i_ff <= i_in;
         j_ff <= j_in;
         k_ff <= k_in;
      end
   end

   assign out_valid = k_vld_ff;
   assign out_pix   = k_ff;

endmodule

// ===== rtl/hsv_pixel_adjust_top.sv =====
// Throughput: one pixel per cycle unless the response side stalls;
// the long divisions are split over four stages.
// A stalled response freezes the whole pipeline, so nothing is lost or repeated.
// Reset clears all stage valid bits and sets mode and amount to zero.
// ----------------------------------------------------------------------------
// HSV pixel adjust top level
// RGB to HSV, one configured adjustment, and HSV back to RGB per pixel.
// ----------------------------------------------------------------------------
module hsv_pixel_adjust_top (
   input  logic        clock,
   input  logic        reset,
   hpa_req_if.sink     req_ch,
   hpa_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_wdata
);
   import hpa_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   pixel_type req_pix, rsp_pix;
   conv_type  conv;
   hsv_type   hsv;
   logic      conv_valid, hsv_valid, rsp_valid, en;

   // Step sizes are derived once per amount write.
   always_comb begin
      logic [9:0]  mag;
      logic [24:0] hue_lo;
      logic [29:0] pct_lo;
      logic [19:0] hue_mag;
      logic [18:0] pct_mag;
      mag = csr_wdata[9] ? 10'(-csr_wdata) : csr_wdata;
      // |a| * 16384 / 15 = 1092 |a| + floor(4 |a| / 15)
      hue_lo  = {13'd0, mag, 2'b00} * 25'd4370;
      hue_mag = 20'({10'd0, mag} * 20'd1092) + {11'd0, hue_lo[24:16]};
      // |a| * 65536 / 100 = 655 |a| + floor(36 |a| / 100)
      pct_lo  = 30'({20'd0, mag} * 30'd36) * 30'd10486;
      pct_mag = 19'({9'd0, mag} * 19'd655) + {9'd0, pct_lo[29:20]};

      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MODE: cfg_in.mode = csr_wdata[2:0];
            CSR_AMOUNT: begin
               cfg_in.amount     = csr_wdata;
               cfg_in.amount_mag = mag;
               cfg_in.hue_step   = csr_wdata[9] ? -$signed(hue_mag) : $signed(hue_mag);
               cfg_in.pct_step   = csr_wdata[9] ? -$signed(pct_mag[17:0])
                                                : $signed(pct_mag[17:0]);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign en            = !rsp_valid || rsp_ch.ready;
   assign req_ch.ready  = en;
   assign req_pix.red       = req_ch.red_in;
   assign req_pix.green     = req_ch.green_in;
   assign req_pix.blue      = req_ch.blue_in;
   assign req_pix.alpha     = req_ch.alpha_in;
   assign req_pix.frame_end = req_ch.frame_end_in;

   hpa_rgb2hsv u_rgb2hsv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_ch.valid),
      .in_pix    (req_pix),
      .cfg       (cfg_ff),
      .out_valid (conv_valid),
      .out_conv  (conv)
   );

   hpa_adjust u_adjust (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (conv_valid),
      .in_conv   (conv),
      .cfg       (cfg_ff),
      .out_valid (hsv_valid),
      .out_hsv   (hsv)
   );

   hpa_hsv2rgb u_hsv2rgb (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (hsv_valid),
      .in_hsv    (hsv),
      .out_valid (rsp_valid),
      .out_pix   (rsp_pix)
   );

   assign rsp_ch.valid         = rsp_valid;
   assign rsp_ch.red_out       = rsp_pix.red;
   assign rsp_ch.green_out     = rsp_pix.green;
   assign rsp_ch.blue_out      = rsp_pix.blue;
   assign rsp_ch.alpha_out     = rsp_pix.alpha;
   assign rsp_ch.frame_end_out = rsp_pix.frame_end;

endmodule
